[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file rsrs_chk.sv.
// Plain text only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/rsrs_pkg.sv]
// Shared constants, types and helper functions for the residual sum block.
// No dependencies.
package rsrs_pkg;

  localparam int unsigned SCAN_AXIS = 1;
  localparam int unsigned COMP_BITS = 21;
  localparam int unsigned VEC_SHIFT = 31 - COMP_BITS;  // Q1.x -> Q1.30
  localparam int unsigned OFS_SHIFT = 25 - COMP_BITS;  // Q9.x -> Q9.16
  localparam int unsigned MW        = 34;              // multiplier operand width
  localparam int unsigned PW        = 2 * MW;          // product width
  localparam int unsigned SW        = 66;              // running sum width

  typedef logic signed [MW-1:0] mop_t;
  typedef logic signed [SW-1:0] wide_t;
  typedef logic signed [31:0]   q16_t;

  localparam logic [62:0] ACC_MAX  = {63{1'b1}};
  localparam q16_t        ONE_Q16  = 32'sh0001_0000;
  localparam q16_t        ONE_Q30  = 32'sh4000_0000;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_LIN   = 2'd1;

  localparam logic [2:0] REG_FOCAL  = 3'd0;
  localparam logic [2:0] REG_RADIAL = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_REFL   = 3'd3;
  localparam logic [2:0] REG_ROT    = 3'd4;
  localparam logic [2:0] REG_ANG    = 3'd5;
  localparam logic [2:0] REG_CAM    = 3'd6;
  localparam logic [2:0] REG_LIN    = 3'd7;

  // 1/k! in Q2.30, rounded to nearest
  function automatic mop_t inv_fact_f(input logic [3:0] k);
    mop_t r;
    case (k)
      4'd0:    r = 34'sd1073741824;
      4'd1:    r = 34'sd1073741824;
      4'd2:    r = 34'sd536870912;
      4'd3:    r = 34'sd178956971;
      4'd4:    r = 34'sd44739243;
      4'd5:    r = 34'sd8947849;
      4'd6:    r = 34'sd1491308;
      4'd7:    r = 34'sd213044;
      4'd8:    r = 34'sd26631;
      4'd9:    r = 34'sd2959;
      4'd10:   r = 34'sd296;
      4'd11:   r = 34'sd27;
      4'd12:   r = 34'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // signed packed component i, shifted up by sh
  function automatic mop_t comp_f(input logic [62:0] pk, input logic [1:0] i,
                                  input int unsigned sh);
    logic signed [COMP_BITS-1:0] c;
    c = signed'(pk[i*COMP_BITS +: COMP_BITS]);
    return mop_t'(c) <<< sh;
  endfunction

  function automatic logic ovf32_f(input wide_t x);
    return x[SW-1:31] != {(SW-31){x[31]}};
  endfunction

  function automatic q16_t sat32_f(input wide_t x);
    q16_t r;
    if (ovf32_f(x)) begin
      r = x[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/rolling_shutter_residual_sum.sv]
// Rolling-shutter residual accumulator. Takes one correspondence word at a time;
// input stall stays high while a word is worked on. Every product goes through
// one shared 34x34 multiplier; a zero radial coefficient skips the three radial
// products of a word. The first word of a set also rebuilds the rotation cache
// and the focal reciprocal: 43 products in exact rotation mode, and the
// bit-serial 48-step reciprocal divider in every mode. The total appears on the
// output after the word marked last.
module rolling_shutter_residual_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [62:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] image_x_i,
  input  logic signed [31:0] image_y_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic signed [31:0] world_z_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [62:0] error_total_o,
  output logic        saturated_o
);
  import rsrs_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_CACHE, ST_ROT, ST_WDIV, ST_ITEM} state_e;

  // configuration
  logic [30:0]        focal_q;
  logic signed [31:0] rad_q;
  logic [1:0]         mode_q;
  logic signed [15:0] refl_q;
  logic [62:0]        rot_q, ang_q, cam_q, lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= 31'd65536000;
      rad_q   <= '0;
      mode_q  <= MODE_EXACT;
      refl_q  <= '0;
      rot_q   <= '0;
      ang_q   <= '0;
      cam_q   <= '0;
      lin_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FOCAL:  focal_q <= cfg_data_i[30:0];
        REG_RADIAL: rad_q   <= cfg_data_i[31:0];
        REG_MODE:   mode_q  <= cfg_data_i[1:0];
        REG_REFL:   refl_q  <= cfg_data_i[15:0];
        REG_ROT:    rot_q   <= cfg_data_i;
        REG_ANG:    ang_q   <= cfg_data_i;
        REG_CAM:    cam_q   <= cfg_data_i;
        REG_LIN:    lin_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  state_e      st_q;
  logic        ph_q, busy_q;
  logic [4:0]  stp_q;
  logic [1:0]  ri_q, rj_q, sub_q;
  wide_t       sum_q;
  mop_t        s_q, ser_q, a_q, b_q, bs_q, tmp_q;
  q16_t        rc_q [9];
  logic [31:0] invf_q;
  logic [62:0] acc_q;
  logic        clip_q;
  q16_t        d_q, u2_q, r2_q, ix_q, iy_q;
  q16_t        xw_q [3];
  q16_t        p_q [3];
  q16_t        c_q [3];
  q16_t        q_q [3];
  logic        last_q;
  logic        out_valid_q, sat_out_q;
  logic [62:0] tot_q;

  mop_t vv [3];
  mop_t ww [3];
  mop_t tt [3];
  mop_t cc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vv[i] = comp_f(rot_q, 2'(i), VEC_SHIFT);
      ww[i] = comp_f(ang_q, 2'(i), VEC_SHIFT);
      tt[i] = comp_f(lin_q, 2'(i), VEC_SHIFT);
      cc[i] = comp_f(cam_q, 2'(i), OFS_SHIFT);
    end
  end

  // skew matrix entry [v]x at (ri, rj)
  mop_t sk_c;
  always_comb begin
    case ({ri_q, rj_q})
      4'b0001: sk_c = -vv[2];
      4'b0010: sk_c = vv[1];
      4'b0100: sk_c = vv[2];
      4'b0110: sk_c = -vv[0];
      4'b1000: sk_c = -vv[1];
      4'b1001: sk_c = vv[0];
      default: sk_c = '0;
    endcase
  end

  logic [3:0] rcix;
  assign rcix = ({2'b00, ri_q} << 1) + {2'b00, ri_q} + {2'b00, rj_q};

  // operand select for the shared multiplier
  mop_t       mul_a, mul_b;
  logic [4:0] sh;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh    = 5'd30;
    case (st_q)
      ST_CACHE: begin
        if (stp_q < 5'd3) begin
          mul_a = vv[stp_q[1:0]];
          mul_b = vv[stp_q[1:0]];
        end else if (stp_q < 5'd15) begin
          mul_a = s_q;
          mul_b = ser_q;
        end else begin
          mul_a = b_q;
          mul_b = s_q;
        end
      end
      ST_ROT: begin
        case (sub_q)
          2'd0: begin
            mul_a = vv[ri_q];
            mul_b = vv[rj_q];
          end
          2'd1: begin
            mul_a = b_q;
            mul_b = tmp_q;
          end
          default: begin
            mul_a = a_q;
            mul_b = sk_c;
          end
        endcase
      end
      ST_ITEM: begin
        case (stp_q)
          5'd0: begin mul_a = mop_t'(ix_q); mul_b = mop_t'(ix_q); sh = 5'd16; end
          5'd1: begin mul_a = mop_t'(iy_q); mul_b = mop_t'(iy_q); sh = 5'd16; end
          5'd2: begin mul_a = mop_t'(rad_q); mul_b = mop_t'(r2_q); end
          5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11: begin
            mul_a = mop_t'(rc_q[rcix]);
            mul_b = mop_t'(xw_q[rj_q]);
          end
          5'd12: begin mul_a = ww[1]; mul_b = mop_t'(p_q[2]); end
          5'd13: begin mul_a = ww[2]; mul_b = mop_t'(p_q[1]); end
          5'd14: begin mul_a = ww[2]; mul_b = mop_t'(p_q[0]); end
          5'd15: begin mul_a = ww[0]; mul_b = mop_t'(p_q[2]); end
          5'd16: begin mul_a = ww[0]; mul_b = mop_t'(p_q[1]); end
          5'd17: begin mul_a = ww[1]; mul_b = mop_t'(p_q[0]); end
          5'd18: begin mul_a = mop_t'(d_q); mul_b = mop_t'(c_q[0]); sh = 5'd16; end
          5'd19: begin mul_a = mop_t'(d_q); mul_b = tt[0]; end
          5'd20: begin mul_a = mop_t'(d_q); mul_b = mop_t'(c_q[1]); sh = 5'd16; end
          5'd21: begin mul_a = mop_t'(d_q); mul_b = tt[1]; end
          5'd22: begin mul_a = mop_t'(d_q); mul_b = mop_t'(c_q[2]); sh = 5'd16; end
          5'd23: begin mul_a = mop_t'(d_q); mul_b = tt[2]; end
          5'd24: begin
            mul_a = mop_t'(q_q[2]);
            mul_b = $signed({2'b00, invf_q});
            sh    = 5'd31;
          end
          5'd25: begin mul_a = mop_t'(iy_q); mul_b = mop_t'(q_q[2]); sh = 5'd0; end
          5'd26: begin mul_a = mop_t'(u2_q); mul_b = mop_t'(q_q[1]); sh = 5'd0; end
          5'd27: begin mul_a = mop_t'(u2_q); mul_b = mop_t'(q_q[0]); sh = 5'd0; end
          5'd28: begin mul_a = mop_t'(ix_q); mul_b = mop_t'(q_q[2]); sh = 5'd0; end
          5'd29: begin mul_a = mop_t'(ix_q); mul_b = mop_t'(q_q[1]); sh = 5'd0; end
          5'd30: begin mul_a = mop_t'(iy_q); mul_b = mop_t'(q_q[0]); sh = 5'd0; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  logic signed [PW-1:0] prod, prod_sh;
  wide_t                tv, sum_add, sum_sub;

  rsrs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_sh = prod >>> sh;
  assign tv      = prod_sh[SW-1:0];
  assign sum_add = sum_q + tv;
  assign sum_sub = sum_q - tv;

  // saturating accumulate of |sum - term|
  wide_t       mag;
  logic [64:0] tsum;
  logic        acc_sat;
  logic [62:0] acc_nx;
  assign mag     = sum_sub[SW-1] ? -sum_sub : sum_sub;
  assign tsum    = {2'b00, acc_q} + {1'b0, mag[63:0]};
  assign acc_sat = tsum[64:63] != 2'b00;
  assign acc_nx  = acc_sat ? ACC_MAX : tsum[62:0];

  // series step index for the Horner evaluation
  logic [5:0] st2, fidx6;
  wide_t      nv;
  assign st2   = {stp_q, 1'b0};
  assign fidx6 = (stp_q < 5'd9) ? 6'd17 - st2 : 6'd30 - st2;
  assign nv    = wide_t'(inv_fact_f(fidx6[3:0])) - tv;

  // scan offset of the incoming word
  q16_t  img_ax;
  wide_t dw, u2w, rotw;
  assign img_ax = (SCAN_AXIS == 1) ? image_y_i : image_x_i;
  assign dw     = wide_t'(img_ax) - (wide_t'(refl_q) <<< 16);
  assign u2w    = wide_t'(ONE_Q16) + tv;
  assign rotw   = sum_add + ((ri_q == rj_q) ? (wide_t'(ONE_Q30) - wide_t'(bs_q)) : '0);

  logic        div_start, div_done;
  logic [47:0] div_quo;
  logic [4:0]  item_start;
  logic        accept, out_hold, out_set;

  assign accept     = (st_q == ST_IDLE) && in_valid_i;
  assign div_start  = accept && !busy_q;
  assign item_start = (rad_q != '0) ? 5'd0 : 5'd3;
  assign out_hold   = out_valid_q && out_stall_i;
  // last word of a set finishing its final accumulate
  assign out_set    = (st_q == ST_ITEM) && ph_q && (stp_q == 5'd30) && last_q && !out_hold;

  rsrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (focal_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ph_q        <= 1'b0;
      busy_q      <= 1'b0;
      stp_q       <= '0;
      ri_q        <= '0;
      rj_q        <= '0;
      sub_q       <= '0;
      sum_q       <= '0;
      s_q         <= '0;
      ser_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      bs_q        <= '0;
      tmp_q       <= '0;
      for (int i = 0; i < 9; i++) begin
        rc_q[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
      end
      invf_q      <= 32'd2147483;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      d_q         <= '0;
      u2_q        <= '0;
      r2_q        <= '0;
      ix_q        <= '0;
      iy_q        <= '0;
      for (int i = 0; i < 3; i++) begin
        xw_q[i] <= '0;
        p_q[i]  <= '0;
        c_q[i]  <= '0;
        q_q[i]  <= '0;
      end
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sat_out_q   <= 1'b0;
      tot_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ix_q    <= image_x_i;
            iy_q    <= image_y_i;
            xw_q[0] <= world_x_i;
            xw_q[1] <= world_y_i;
            xw_q[2] <= world_z_i;
            last_q  <= last_i;
            d_q     <= sat32_f(dw);
            u2_q    <= ONE_Q16;
            ri_q    <= '0;
            rj_q    <= '0;
            sub_q   <= '0;
            ph_q    <= 1'b0;
            if (!busy_q) begin
              busy_q <= 1'b1;
              acc_q  <= '0;
              clip_q <= ovf32_f(dw);
              if (mode_q == MODE_EXACT) begin
                st_q  <= ST_CACHE;
                stp_q <= '0;
                ser_q <= inv_fact_f(4'd13);
              end else begin
                if (mode_q == MODE_LIN) begin
                  rc_q[0] <= ONE_Q30;
                  rc_q[1] <= q16_t'(-vv[2]);
                  rc_q[2] <= q16_t'(vv[1]);
                  rc_q[3] <= q16_t'(vv[2]);
                  rc_q[4] <= ONE_Q30;
                  rc_q[5] <= q16_t'(-vv[0]);
                  rc_q[6] <= q16_t'(-vv[1]);
                  rc_q[7] <= q16_t'(vv[0]);
                  rc_q[8] <= ONE_Q30;
                end else begin
                  for (int i = 0; i < 9; i++) begin
                    rc_q[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
                  end
                end
                st_q <= ST_WDIV;
              end
            end else begin
              clip_q <= clip_q | ovf32_f(dw);
              st_q   <= ST_ITEM;
              stp_q  <= item_start;
            end
          end
        end

        ST_CACHE: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            stp_q <= stp_q + 5'd1;
            if (stp_q == 5'd0) begin
              sum_q <= tv;
            end else if (stp_q == 5'd1) begin
              sum_q <= sum_add;
            end else if (stp_q == 5'd2) begin
              s_q <= sum_add[MW-1:0];
            end else if (stp_q < 5'd15) begin
              // end of the first series: seed the second
              if (stp_q == 5'd8) begin
                a_q   <= nv[MW-1:0];
                ser_q <= inv_fact_f(4'd14);
              end else begin
                ser_q <= nv[MW-1:0];
              end
              if (stp_q == 5'd14) begin
                b_q <= nv[MW-1:0];
              end
            end else begin
              bs_q  <= tv[MW-1:0];
              st_q  <= ST_ROT;
              sub_q <= '0;
              ri_q  <= '0;
              rj_q  <= '0;
            end
          end
        end

        ST_ROT: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            case (sub_q)
              2'd0: begin
                tmp_q <= tv[MW-1:0];
                sub_q <= 2'd1;
              end
              2'd1: begin
                sum_q <= tv;
                sub_q <= 2'd2;
              end
              default: begin
                rc_q[rcix] <= sat32_f(rotw);
                clip_q     <= clip_q | ovf32_f(rotw);
                sub_q      <= 2'd0;
                if (rj_q == 2'd2) begin
                  rj_q <= 2'd0;
                  if (ri_q == 2'd2) begin
                    ri_q <= 2'd0;
                    st_q <= ST_WDIV;
                  end else begin
                    ri_q <= ri_q + 2'd1;
                  end
                end else begin
                  rj_q <= rj_q + 2'd1;
                end
              end
            endcase
          end
        end

        ST_WDIV: begin
          if (div_done) begin
            invf_q <= (div_quo[47:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
            clip_q <= clip_q | (div_quo[47:32] != '0);
            st_q   <= ST_ITEM;
            stp_q  <= item_start;
            ph_q   <= 1'b0;
          end
        end

        ST_ITEM: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else if (!(stp_q == 5'd30 && last_q && out_hold)) begin
            ph_q  <= 1'b0;
            stp_q <= stp_q + 5'd1;
            case (stp_q)
              5'd0: sum_q <= tv;
              5'd1: begin
                r2_q   <= sat32_f(sum_add);
                clip_q <= clip_q | ovf32_f(sum_add);
              end
              5'd2: begin
                u2_q   <= sat32_f(u2w);
                clip_q <= clip_q | ovf32_f(u2w);
              end
              5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11: begin
                if (rj_q == 2'd0) begin
                  sum_q <= tv;
                  rj_q  <= 2'd1;
                end else if (rj_q == 2'd1) begin
                  sum_q <= sum_add;
                  rj_q  <= 2'd2;
                end else begin
                  p_q[ri_q] <= sat32_f(sum_add);
                  clip_q    <= clip_q | ovf32_f(sum_add);
                  rj_q      <= 2'd0;
                  ri_q      <= (ri_q == 2'd2) ? 2'd0 : ri_q + 2'd1;
                end
              end
              5'd12, 5'd14, 5'd16, 5'd25, 5'd27, 5'd29: sum_q <= tv;
              5'd13: begin
                c_q[0] <= sat32_f(sum_sub);
                clip_q <= clip_q | ovf32_f(sum_sub);
              end
              5'd15: begin
                c_q[1] <= sat32_f(sum_sub);
                clip_q <= clip_q | ovf32_f(sum_sub);
              end
              5'd17: begin
                c_q[2] <= sat32_f(sum_sub);
                clip_q <= clip_q | ovf32_f(sum_sub);
              end
              5'd18: sum_q <= wide_t'(p_q[0]) + wide_t'(cc[0]) + tv;
              5'd20: sum_q <= wide_t'(p_q[1]) + wide_t'(cc[1]) + tv;
              5'd22: sum_q <= wide_t'(p_q[2]) + wide_t'(cc[2]) + tv;
              5'd19: begin
                q_q[0] <= sat32_f(sum_add);
                clip_q <= clip_q | ovf32_f(sum_add);
              end
              5'd21: begin
                q_q[1] <= sat32_f(sum_add);
                clip_q <= clip_q | ovf32_f(sum_add);
              end
              5'd23: begin
                q_q[2] <= sat32_f(sum_add);
                clip_q <= clip_q | ovf32_f(sum_add);
              end
              5'd24: begin
                q_q[2] <= sat32_f(tv);
                clip_q <= clip_q | ovf32_f(tv);
              end
              5'd26, 5'd28: begin
                acc_q  <= acc_nx;
                clip_q <= clip_q | acc_sat;
              end
              5'd30: begin
                acc_q  <= acc_nx;
                clip_q <= clip_q | acc_sat;
                st_q   <= ST_IDLE;
                if (last_q) begin
                  busy_q      <= 1'b0;
                  tot_q       <= acc_nx;
                  sat_out_q   <= clip_q | acc_sat;
                end
              end
              default: ;
            endcase
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (st_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign error_total_o = tot_q;
  assign saturated_o   = sat_out_q;

endmodule

[hw/rtl/rsrs_mul.sv]
// Shared signed multiplier with registered product.
// Depends on rsrs_pkg.
module rsrs_mul (
  input  logic                           clk_i,
  input  rsrs_pkg::mop_t                 a_i,
  input  rsrs_pkg::mop_t                 b_i,
  output logic signed [rsrs_pkg::PW-1:0] p_o
);
  import rsrs_pkg::*;

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/rsrs_div.sv]
// Restoring divider for 2^47 / focal length, one quotient bit a cycle.
// Depends on rsrs_pkg only for house style; standalone arithmetic.
module rsrs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] den_i,
  output logic        done_o,
  output logic [47:0] quo_o
);
  import rsrs_pkg::*;

  logic [30:0] den_q, rem_q;
  logic [47:0] quo_q;
  logic [5:0]  bit_q;
  logic        run_q, done_q;
  logic [31:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  // dividend is a single set bit at position 47
  assign rem_sh = {rem_q, bit_q == 6'd47};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = !diff[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      bit_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      den_q  <= den_i;
      rem_q  <= '0;
      quo_q  <= '0;
      bit_q  <= 6'd47;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q <= ge ? diff[30:0] : rem_sh[30:0];
      quo_q <= {quo_q[46:0], ge};
      if (bit_q == 6'd0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        bit_q <= bit_q - 6'd1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hw/rtl/rsrs_chk.sv]
// Port-level checker for the residual sum block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rsrs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [62:0] error_total_o,
  input logic        saturated_o
);

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(error_total_o) && $stable(saturated_o))

  // an accepted word keeps the input stalled while it is worked on
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // no word is taken on consecutive cycles
  `ASSERT_NEXT(a_no_b2b, clk_i, rst_ni, in_valid_i && !in_stall_o, !(in_valid_i && !in_stall_o))

  // a result only appears at the end of a word's processing
  `ASSERT_IMPL(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind rolling_shutter_residual_sum rsrs_chk u_rsrs_chk (.*);

[dv/tb_rolling_shutter_residual_sum.sv]
// Testbench for rolling_shutter_residual_sum: streams correspondence sets, predicts each
// set total in a local fixed-point model, compares on the output side. Depends on rsrs_pkg.
`timescale 1ns / 100ps

module tb_rolling_shutter_residual_sum;
  import rsrs_pkg::*;

  typedef struct packed {
    logic signed [31:0] ix, iy, wx, wy, wz;
    logic               lst;
  } corr_t;

  typedef struct packed {
    logic [62:0] total;
    logic        sat;
  } total_t;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [62:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic signed [31:0] image_x_i = 0, image_y_i = 0, world_x_i = 0, world_y_i = 0;
  logic signed [31:0] world_z_i = 0;
  logic        last_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [62:0] error_total_o;
  logic        saturated_o;

  rolling_shutter_residual_sum uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // shadow registers and state
  longint unsigned m_focal, m_radial, m_mode, m_refl, m_rot, m_ang, m_cam, m_lin;
  longint m_rc[9];
  longint unsigned m_invf, m_acc;
  bit m_clip, m_busy;

  corr_t  pend_words[$];
  total_t exp_totals[$];
  int     n_err = 0;
  bit     idle_en = 1, hold_rx = 0, fill_rx = 0;
  int     hold_cnt = 0;

  function automatic longint fsra(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint sxt(longint unsigned v, int bits);
    longint unsigned m;
    m = v & ((64'd1 << bits) - 1);
    if (m[bits-1]) return longint'(m) - (longint'(1) << bits);
    return longint'(m);
  endfunction

  function automatic longint vcomp(longint unsigned pk, int i);
    return sxt(pk >> (i * COMP_BITS), COMP_BITS);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) begin m_clip = 1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin m_clip = 1; return -64'sd2147483648; end
    return x;
  endfunction

  function automatic longint fact_q30(int k);
    longint t[15] = '{1073741824, 1073741824, 536870912, 178956971, 44739243, 8947849,
                      1491308, 213044, 26631, 2959, 296, 27, 2, 0, 0};
    return t[k];
  endfunction

  function automatic longint trig_series(longint s, int first);
    longint a;
    a = fact_q30(first + 12);
    for (int k = 5; k >= 0; k--) a = fact_q30(first + 2 * k) - fsra(s * a, 30);
    return a;
  endfunction

  function automatic void load_rotation();
    longint v[3], r[9], sk[9], s, a, b, e;
    longint unsigned q;
    for (int i = 0; i < 3; i++) v[i] = vcomp(m_rot, i) <<< VEC_SHIFT;
    for (int i = 0; i < 9; i++) begin sk[i] = 0; r[i] = (i % 4 == 0) ? 64'sd1 <<< 30 : 0; end
    sk[1] = -v[2]; sk[2] = v[1]; sk[3] = v[2]; sk[5] = -v[0]; sk[6] = -v[1]; sk[7] = v[0];
    if (m_mode == MODE_EXACT) begin
      s = fsra(v[0]*v[0], 30) + fsra(v[1]*v[1], 30) + fsra(v[2]*v[2], 30);
      a = trig_series(s, 1);
      b = trig_series(s, 2);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          e = fsra(b * fsra(v[i]*v[j], 30), 30) + fsra(a * sk[i*3+j], 30);
          if (i == j) e += (64'sd1 <<< 30) - fsra(b * s, 30);
          r[i*3+j] = e;
        end
    end else if (m_mode == MODE_LIN) begin
      for (int i = 0; i < 9; i++) r[i] += sk[i];
    end
    for (int i = 0; i < 9; i++) m_rc[i] = clip32(r[i]);
    if (m_focal == 0) begin
      m_invf = 64'hFFFF_FFFF; m_clip = 1;
    end else begin
      q = (64'd1 << 47) / m_focal;
      if (q > 64'hFFFF_FFFF) begin q = 64'hFFFF_FFFF; m_clip = 1; end
      m_invf = q;
    end
  endfunction

  function automatic void add_abs(longint e);
    longint unsigned m, t;
    m = (e < 0) ? -e : e;
    t = m_acc + m;
    if (t > 64'h7FFF_FFFF_FFFF_FFFF) begin t = 64'h7FFF_FFFF_FFFF_FFFF; m_clip = 1; end
    m_acc = t;
  endfunction

  // returns 1 and the set total when the word closes a set
  function automatic bit residual_step(corr_t c, output total_t res);
    longint img[2], xw[3], p[3], w[3], cr[3], q[3], u[3], d, rd, r2, cc, tt;
    res = '0;
    if (!m_busy) begin
      m_acc = 0; m_clip = 0; load_rotation(); m_busy = 1;
    end
    img[0] = c.ix; img[1] = c.iy; xw[0] = c.wx; xw[1] = c.wy; xw[2] = c.wz;
    d = clip32(img[SCAN_AXIS] - sxt(m_refl, 16) * 65536);
    u[0] = img[0]; u[1] = img[1]; u[2] = 65536;
    rd = sxt(m_radial, 32);
    if (rd != 0) begin
      r2 = clip32(fsra(img[0]*img[0], 16) + fsra(img[1]*img[1], 16));
      u[2] = clip32(65536 + fsra(rd * r2, 30));
    end
    for (int i = 0; i < 3; i++)
      p[i] = clip32(fsra(m_rc[i*3]*xw[0], 30) + fsra(m_rc[i*3+1]*xw[1], 30)
                    + fsra(m_rc[i*3+2]*xw[2], 30));
    for (int i = 0; i < 3; i++) w[i] = vcomp(m_ang, i) <<< VEC_SHIFT;
    cr[0] = clip32(fsra(w[1]*p[2], 30) - fsra(w[2]*p[1], 30));
    cr[1] = clip32(fsra(w[2]*p[0], 30) - fsra(w[0]*p[2], 30));
    cr[2] = clip32(fsra(w[0]*p[1], 30) - fsra(w[1]*p[0], 30));
    for (int i = 0; i < 3; i++) begin
      cc = vcomp(m_cam, i) <<< OFS_SHIFT;
      tt = vcomp(m_lin, i) <<< VEC_SHIFT;
      q[i] = clip32(p[i] + fsra(d * cr[i], 16) + cc + fsra(d * tt, 30));
    end
    q[2] = clip32(fsra(q[2] * longint'(m_invf), 31));
    add_abs(u[1]*q[2] - u[2]*q[1]);
    add_abs(u[2]*q[0] - u[0]*q[2]);
    add_abs(u[0]*q[1] - u[1]*q[0]);
    if (!c.lst) return 0;
    m_busy = 0;
    res.total = m_acc[62:0];
    res.sat = m_clip;
    return 1;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        total_t r;
        corr_t c;
        c = '{image_x_i, image_y_i, world_x_i, world_y_i, world_z_i, last_i};
        if (residual_step(c, r)) exp_totals.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pend_words.size() > 0 && !(idle_en && $urandom_range(99) < 10)) begin
          corr_t c;
          c = pend_words.pop_front();
          in_valid_i <= 1;
          image_x_i <= c.ix; image_y_i <= c.iy;
          world_x_i <= c.wx; world_y_i <= c.wy; world_z_i <= c.wz;
          last_i <= c.lst;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_totals.size() == 0) begin
          n_err++;
          $display("%0t: unexpected total %h sat %b", $time, error_total_o, saturated_o);
        end else begin
          total_t e;
          e = exp_totals.pop_front();
          if (e.total !== error_total_o) begin
            n_err++;
            $display("%0t: error_total exp %h got %h", $time, e.total, error_total_o);
          end
          if (e.sat !== saturated_o) begin
            n_err++;
            $display("%0t: saturated exp %b got %b", $time, e.sat, saturated_o);
          end
        end
      end
      if (hold_rx) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt > 3000) hold_rx <= 0;
        out_stall_i <= 1;
      end else begin
        hold_cnt <= 0;
        out_stall_i <= idle_en && ($urandom_range(99) < 10);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    case (idx)
      REG_FOCAL:  m_focal = val & 63'h7FFF_FFFF;
      REG_RADIAL: m_radial = val & 63'hFFFF_FFFF;
      REG_MODE:   m_mode = val & 3;
      REG_REFL:   m_refl = val & 16'hFFFF;
      REG_ROT:    m_rot = val;
      REG_ANG:    m_ang = val;
      REG_CAM:    m_cam = val;
      default:    m_lin = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (pend_words.size() > 0 || in_valid_i || exp_totals.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(65535 * 512)) - 32'sd16777216;
    endcase
  endfunction

  function automatic logic [62:0] rand_vec(bit tiny);
    logic [62:0] v;
    v = {$urandom, $urandom};
    if (tiny)
      for (int i = 0; i < 3; i++)
        v[i*COMP_BITS +: COMP_BITS] = $signed($urandom_range(4000)) - 2000;
    return v;
  endfunction

  task automatic queue_set(input int len);
    corr_t c;
    for (int i = 0; i < len; i++) begin
      c.ix = rand_coord(); c.iy = rand_coord();
      c.wx = rand_coord(); c.wy = rand_coord(); c.wz = rand_coord();
      c.lst = (i == len - 1);
      pend_words.push_back(c);
    end
  endtask

  task automatic random_config();
    write_reg(REG_FOCAL, ($urandom_range(3) == 0) ? 63'($urandom_range(3)) :
                         63'($urandom & 32'h7FFF_FFFF));
    write_reg(REG_RADIAL, ($urandom_range(2) == 0) ? 63'd0 : 63'($urandom));
    write_reg(REG_MODE, $urandom_range(3));
    write_reg(REG_REFL, $urandom);
    write_reg(REG_ROT, rand_vec($urandom_range(1)));
    write_reg(REG_ANG, rand_vec($urandom_range(2) > 0));
    write_reg(REG_CAM, rand_vec(0));
    write_reg(REG_LIN, rand_vec($urandom_range(1)));
  endtask

  initial begin
    corr_t c;
    m_focal = 65536000; m_radial = 0; m_mode = 0; m_refl = 0;
    m_rot = 0; m_ang = 0; m_cam = 0; m_lin = 0;
    for (int i = 0; i < 9; i++) m_rc[i] = (i % 4 == 0) ? 64'sd1 <<< 30 : 0;
    m_invf = 2147483; m_acc = 0; m_clip = 0; m_busy = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // reset settings: extremes of the fields, single-word and longer sets
    c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1};
    pend_words.push_back(c);
    c = '{0, 0, 0, 0, 0, 1};
    pend_words.push_back(c);
    c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1};
    pend_words.push_back(c);
    queue_set(4);
    drain();
    // extreme register values: zero focal, undefined mode, saturating vectors
    write_reg(REG_FOCAL, 0); write_reg(REG_RADIAL, 63'h8000_0000);
    write_reg(REG_MODE, 3); write_reg(REG_REFL, 16'h8000);
    write_reg(REG_ROT, '1); write_reg(REG_ANG, '1);
    write_reg(REG_CAM, 63'h7FFF_FFFF_FFFF_FFFF); write_reg(REG_LIN, '1);
    queue_set(3); queue_set(1);
    drain();
    write_reg(REG_FOCAL, 63'h7FFF_FFFF); write_reg(REG_RADIAL, 63'h7FFF_FFFF);
    write_reg(REG_MODE, 1); write_reg(REG_REFL, 16'h7FFF);
    queue_set(3);
    drain();
    write_reg(REG_FOCAL, 65536); write_reg(REG_MODE, 2);
    queue_set(3);
    drain();

    for (int ph = 0; ph < 30; ph++) begin
      random_config();
      idle_en = (ph % 7 != 3);
      if (ph == 5) begin
        hold_rx = 1;
        for (int k = 0; k < 40; k++) queue_set(1);
      end
      for (int k = 0; k < 40; ) begin
        int len;
        len = $urandom_range(1, 8);
        queue_set(len);
        k += len;
      end
      drain();
    end

    if (n_err == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rsrs_pkg.sv
hw/rtl/rsrs_mul.sv
hw/rtl/rsrs_div.sv
hw/rtl/rolling_shutter_residual_sum.sv
hw/rtl/rsrs_chk.sv
dv/tb_rolling_shutter_residual_sum.sv
